[src/rgse_pkg.sv]
// Package for the RGB-to-grey Sobel edge block: word types, register map,
// sizing defaults and the grey conversion weights.
// No dependencies; used by the top level and its checker.
package rgse_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 4096;

  // Configuration port layout.
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned CFG_W    = 12;
  localparam logic        REG_IDX_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 12'd640;
  localparam logic [CFG_W-1:0] MIN_WIDTH       = 12'd3;

  // Grey conversion weights (sum of weights is 256).
  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd29;

  // Input word: one RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  // Output word: edge magnitude with window centre position.
  typedef struct packed {
    logic [7:0]  edge_value;
    logic [11:0] centre_row;
    logic [10:0] centre_col;
  } edge_out_t;

  // Grey level as (77*R + 150*G + 29*B) >> 8.
  function automatic logic [7:0] rgb_to_grey(input pix_in_t p);
    logic [15:0] acc;
    acc = 16'(W_RED) * 16'(p.red) + 16'(W_GREEN) * 16'(p.green)
        + 16'(W_BLUE) * 16'(p.blue);
    return acc[15:8];
  endfunction

endpackage

[src/rgb_grey_sobel_edge.sv]
// Top level of the RGB-to-grey 3x3 Sobel edge detector.
// Depends on rgse_pkg for word types, register map and constants.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) takes one RGB pixel
//   word per cycle while in_ready_o is high, in raster order; frame_start
//   marks the first pixel of a frame and clears the row and column counts.
//   The output channel (out_valid_o/out_ready_i/out_data_o) gives one edge
//   word for every pixel whose 3x3 window is complete (row >= 2 and column
//   >= 2), carrying the window centre position. Other pixels give no word.
//   The image width register sits at APB byte address 0 and must be written
//   only while the block is idle; the block itself does not enforce this.
//   Values below 3 act as 3, above MAX_WIDTH as MAX_WIDTH.
//   Throughput is one pixel per cycle while in_ready_o is high: the two line
//   stores are synchronous memories with one read port and one write port,
//   each read once at accept and written once in the following cycle, with
//   a bypass for a read of the entry being written.
//   An accepted word passes the stage register and then the output queue
//   before it shows on out_valid_o. A three-word output queue decouples the
//   receiver; when it stalls, input is still taken until the queue and the
//   stage in flight hold three words.
//   Reset clears counters, window registers, the queue and sets the width
//   to 640. Line store contents are not cleared and need no clearing pass.
module rgb_grey_sobel_edge
  import rgse_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Pixel input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pix_in_t            in_data_i,
  // Edge output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output edge_out_t          out_data_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CmpW  = (ColW + 1 > CFG_W) ? ColW + 1 : CFG_W;
  localparam logic [CmpW-1:0] MaxWidthC   = CmpW'(MAX_WIDTH);
  localparam logic [RowW-1:0] RowLast     = RowW'(MAX_HEIGHT - 1);
  localparam int unsigned OutDepth = 3;
  localparam int unsigned PtrW     = 2;
  localparam int unsigned CntW     = 2;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_q;
  logic             cfg_wr;
  logic             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1] == REG_IDX_IMAGE_WIDTH);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= IMAGE_WIDTH_RST;
    end else if (cfg_wr) begin
      width_q <= pwdata[CFG_W-1:0];
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = PDATA_W'(width_q);
    end
  end

  // Width in use, clamped to the legal range.
  logic [CmpW-1:0] width_eff;
  always_comb begin
    width_eff = CmpW'(width_q);
    if (width_q < MIN_WIDTH) begin
      width_eff = CmpW'(MIN_WIDTH);
    end else if (CmpW'(width_q) > MaxWidthC) begin
      width_eff = MaxWidthC;
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: position counters and line store reads
  // ---------------------------------------------------------------------
  logic            in_fire;
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [RowW-1:0] row_q, row_d, row_cur;
  logic [CntW-1:0] cnt_q;
  logic            s1_valid_q;

  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = ({1'b0, cnt_q} + {{CntW{1'b0}}, s1_valid_q}) < (CntW + 1)'(OutDepth);

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    col_d   = col_cur + 1'b1;
    row_d   = row_cur;
    if ((CmpW'(col_cur) + 1'b1) >= width_eff) begin
      col_d = '0;
      if (row_cur < RowLast) begin
        row_d = row_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: one read at accept, one write from the compute stage
  // ---------------------------------------------------------------------
  logic [7:0]      upper_mem  [MAX_WIDTH];
  logic [7:0]      middle_mem [MAX_WIDTH];
  logic [7:0]      up_rd_q, mid_rd_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [7:0]      s1_grey_q;
  logic            s1_full_q;
  logic            fwd_q;
  logic [7:0]      fwd_top_q, fwd_mid_q;
  logic [7:0]      top, mid;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      up_rd_q <= upper_mem[col_cur];
    end
    if (s1_valid_q) begin
      upper_mem[s1_col_q] <= mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mid_rd_q <= middle_mem[col_cur];
    end
    if (s1_valid_q) begin
      middle_mem[s1_col_q] <= s1_grey_q;
    end
  end

  // Stage register; the bypass covers a read of the entry written this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q  <= col_cur;
      s1_row_q  <= row_cur;
      s1_grey_q <= rgb_to_grey(in_data_i);
      s1_full_q <= (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));
      fwd_q     <= s1_valid_q && (s1_col_q == col_cur);
      fwd_top_q <= mid;
      fwd_mid_q <= s1_grey_q;
    end
  end

  assign top = fwd_q ? fwd_top_q : up_rd_q;
  assign mid = fwd_q ? fwd_mid_q : mid_rd_q;

  // ---------------------------------------------------------------------
  // Compute stage: window registers and Sobel magnitude
  // ---------------------------------------------------------------------
  // win_q[0..2]: two columns back (top, mid, bottom); win_q[3..5]: one back.
  logic [7:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_grey_q;
    end
  end

  logic signed [11:0] gx, gy;
  logic        [11:0] mag;
  logic        [7:0]  edge_sat;

  always_comb begin
    gx = ($signed({4'b0, top}) + $signed({3'b0, mid, 1'b0}) + $signed({4'b0, s1_grey_q}))
       - ($signed({4'b0, win_q[0]}) + $signed({3'b0, win_q[1], 1'b0})
          + $signed({4'b0, win_q[2]}));
    gy = ($signed({4'b0, win_q[0]}) + $signed({3'b0, win_q[3], 1'b0}) + $signed({4'b0, top}))
       - ($signed({4'b0, win_q[2]}) + $signed({3'b0, win_q[5], 1'b0})
          + $signed({4'b0, s1_grey_q}));
    mag = (gx[11] ? 12'(-gx) : 12'(gx)) + (gy[11] ? 12'(-gy) : 12'(gy));
    edge_sat = (mag > 12'd255) ? 8'hFF : mag[7:0];
  end

  edge_out_t       res;
  logic [RowW-1:0] row_m1;
  logic [ColW-1:0] col_m1;

  always_comb begin
    row_m1         = s1_row_q - 1'b1;
    col_m1         = s1_col_q - 1'b1;
    res.edge_value = edge_sat;
    res.centre_row = 12'(row_m1);
    res.centre_col = 11'(col_m1);
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  edge_out_t       fifo_q [OutDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic            push, pop;

  assign push        = s1_valid_q && s1_full_q;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/rgse_checker.sv]
// Port-level checker for rgb_grey_sobel_edge, attached by a bind statement.
// Depends on rgse_pkg and the top level's port list.
module rgse_checker
  import rgse_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input pix_in_t            in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input edge_out_t          out_data_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // A waiting input word holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // A width write reads back on the next cycle at the same address.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_IDX_IMAGE_WIDTH)
    |=> ((paddr[PADDR_W-1] != REG_IDX_IMAGE_WIDTH) ||
         (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))))
    else $error("image width read back differs from the write");

  // A full window never centres on the first row or column.
  a_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.centre_row != '0) && (out_data_o.centre_col != '0))
    else $error("edge word centred on the image border");

endmodule

bind rgb_grey_sobel_edge rgse_checker u_rgse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
